// ===== rtl/core/gcpms_pkg.sv =====
// shared types, constants and arithmetic helpers for the crossing-paths block
`timescale 1ns / 1ps

package gcpms_pkg;

    localparam int CELL_W  = 17;
    localparam int TOTAL_W = 27;
    localparam int CFG_W   = 8;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // register map (byte address bit 2 selects the register)
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // table numbering: bit 0 set walks rows upwards, bit 1 set walks columns leftwards
    localparam logic [1:0] TBL_TL = 2'd0;
    localparam logic [1:0] TBL_BL = 2'd1;
    localparam logic [1:0] TBL_TR = 2'd2;
    localparam logic [1:0] TBL_BR = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic load_wr;
        logic build_init;
        logic build_rd;
        logic build_wr;
        logic eval_init;
        logic eval_rd_a;
        logic eval_rd_b;
        logic eval_sum_b;
        logic eval_acc;
        logic out_load;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic last_cell;
        logic tbl_cell_last;
        logic tbl_last;
        logic small_grid;
        logic eval_last;
        logic out_busy;
    } status_t;

    // saturating add of two path sums
    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                   input logic [TOTAL_W-1:0] b);
        logic [TOTAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TOTAL_W] ? TOTAL_MAX : s[TOTAL_W-1:0];
    endfunction

    // saturating sum of four path sums
    function automatic logic [TOTAL_W-1:0] sum4(input logic [TOTAL_W-1:0] p,
                                                input logic [TOTAL_W-1:0] q,
                                                input logic [TOTAL_W-1:0] s,
                                                input logic [TOTAL_W-1:0] u);
        return sat_add(sat_add(p, q), sat_add(s, u));
    endfunction

endpackage

// ===== rtl/core/gcpms_in_if.sv =====
// cell input channel
`timescale 1ns / 1ps

interface gcpms_in_if;
    logic                        valid;
    logic                        ready;
    logic [gcpms_pkg::CELL_W-1:0] cell_value;

    modport source (output valid, output cell_value, input ready);
    modport sink (input valid, input cell_value, output ready);
endinterface

// ===== rtl/core/gcpms_out_if.sv =====
// result output channel
`timescale 1ns / 1ps

interface gcpms_out_if;
    logic                         valid;
    logic                         ready;
    logic [gcpms_pkg::TOTAL_W-1:0] best_total;

    modport source (output valid, output best_total, input ready);
    modport sink (input valid, input best_total, output ready);
endinterface

// ===== rtl/core/gcpms_ctrl.sv =====
// sequencing state machine for load, table build and evaluation
`timescale 1ns / 1ps

module gcpms_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  gcpms_pkg::status_t status,
    output gcpms_pkg::cmd_t    cmd
);

    typedef enum logic [9:0] {
        S_LOAD   = 10'b0000000001,
        S_BINIT  = 10'b0000000010,
        S_BRD    = 10'b0000000100,
        S_BWR    = 10'b0000001000,
        S_EINIT  = 10'b0000010000,
        S_ERDA   = 10'b0000100000,
        S_ERDB   = 10'b0001000000,
        S_ESUM   = 10'b0010000000,
        S_EACC   = 10'b0100000000,
        S_FINISH = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_fire;

    assign in_ready = (state_reg == S_LOAD);
    assign in_fire  = in_valid && in_ready;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_LOAD:
            begin
                cmd.load_wr = in_fire;
                if (in_fire && status.last_cell)
                begin
                    state_next = S_BINIT;
                end
            end
            S_BINIT:
            begin
                cmd.build_init = 1'b1;
                state_next     = S_BRD;
            end
            S_BRD:
            begin
                cmd.build_rd = 1'b1;
                state_next   = S_BWR;
            end
            S_BWR:
            begin
                cmd.build_wr = 1'b1;
                if (!status.tbl_cell_last)
                begin
                    state_next = S_BRD;
                end
                else if (!status.tbl_last)
                begin
                    state_next = S_BINIT;
                end
                else if (status.small_grid)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_EINIT;
                end
            end
            S_EINIT:
            begin
                cmd.eval_init = 1'b1;
                state_next    = S_ERDA;
            end
            S_ERDA:
            begin
                cmd.eval_rd_a = 1'b1;
                state_next    = S_ERDB;
            end
            S_ERDB:
            begin
                cmd.eval_rd_b = 1'b1;
                state_next    = S_ESUM;
            end
            S_ESUM:
            begin
                cmd.eval_sum_b = 1'b1;
                state_next     = S_EACC;
            end
            S_EACC:
            begin
                cmd.eval_acc = 1'b1;
                state_next   = status.eval_last ? S_FINISH : S_ERDA;
            end
            S_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/gcpms_dp.sv =====
// datapath: cell store, four path tables, counters and result register
`timescale 1ns / 1ps

module gcpms_dp #(
    parameter int MAX_DIM = 128
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load_clear,
    input  logic [$clog2(MAX_DIM)-1:0]     row_last,
    input  logic [$clog2(MAX_DIM)-1:0]     col_last,
    input  logic                           small_grid,
    input  logic [gcpms_pkg::CELL_W-1:0]   cell_value,
    input  gcpms_pkg::cmd_t                cmd,
    output gcpms_pkg::status_t             status,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [gcpms_pkg::TOTAL_W-1:0]  best_total
);

    localparam int DW    = $clog2(MAX_DIM);
    localparam int AW    = 2 * DW;
    localparam int DEPTH = 1 << AW;
    localparam int TW    = gcpms_pkg::TOTAL_W;
    localparam int CW    = gcpms_pkg::CELL_W;

    logic [DW-1:0] lrow_reg, lcol_reg;
    logic [DW-1:0] bi_reg, bj_reg;
    logic [DW-1:0] ei_reg, ej_reg;
    logic [1:0]    tbl_reg;
    logic [TW-1:0] left_reg;
    logic          up_oob_reg;
    logic [CW-1:0] cell_q_reg;
    logic [TW-1:0] t1_reg, t2_reg, best_reg;
    logic          out_valid_reg;
    logic [TW-1:0] out_total_reg;

    logic [DW-1:0] istart, iend, jstart, jend, inext, jnext, iup;
    logic [DW-1:0] eim, eip, ejm, ejp, erow_end, ecol_end;
    logic [AW-1:0] raddr [4];
    logic [TW-1:0] q     [4];
    logic [TW-1:0] up_val, prev_val, new_val;
    logic [TW-1:0] eval_sum;

    // walk direction of the current table
    assign istart = tbl_reg[0] ? row_last : '0;
    assign iend   = tbl_reg[0] ? '0 : row_last;
    assign jstart = tbl_reg[1] ? col_last : '0;
    assign jend   = tbl_reg[1] ? '0 : col_last;
    assign inext  = tbl_reg[0] ? bi_reg - DW'(1) : bi_reg + DW'(1);
    assign jnext  = tbl_reg[1] ? bj_reg - DW'(1) : bj_reg + DW'(1);
    assign iup    = tbl_reg[0] ? bi_reg + DW'(1) : bi_reg - DW'(1);

    // neighbour coordinates of the meeting cell
    assign eim      = ei_reg - DW'(1);
    assign eip      = ei_reg + DW'(1);
    assign ejm      = ej_reg - DW'(1);
    assign ejp      = ej_reg + DW'(1);
    assign erow_end = row_last - DW'(1);
    assign ecol_end = col_last - DW'(1);

    // table read addresses: predecessor row in build, two crossing sets in evaluation
    always_comb
    begin
        for (int t = 0; t < 4; t++)
        begin
            raddr[t] = {iup, bj_reg};
        end
        if (cmd.eval_rd_a)
        begin
            raddr[gcpms_pkg::TBL_TL] = {eim, ej_reg};
            raddr[gcpms_pkg::TBL_BL] = {ei_reg, ejm};
            raddr[gcpms_pkg::TBL_TR] = {ei_reg, ejp};
            raddr[gcpms_pkg::TBL_BR] = {eip, ej_reg};
        end
        else if (!cmd.build_rd)
        begin
            raddr[gcpms_pkg::TBL_TL] = {ei_reg, ejm};
            raddr[gcpms_pkg::TBL_BL] = {eip, ej_reg};
            raddr[gcpms_pkg::TBL_TR] = {eim, ej_reg};
            raddr[gcpms_pkg::TBL_BR] = {ei_reg, ejp};
        end
    end

    // new table entry
    assign up_val   = up_oob_reg ? '0 : q[tbl_reg];
    assign prev_val = (up_val > left_reg) ? up_val : left_reg;
    assign new_val  = gcpms_pkg::sat_add(TW'(cell_q_reg), prev_val);
    assign eval_sum = gcpms_pkg::sum4(q[0], q[1], q[2], q[3]);

    // path table memories
    for (genvar g = 0; g < 4; g++)
    begin : g_tbl
        logic [TW-1:0] mem [DEPTH];

        always_ff @(posedge clk)
        begin
            if (cmd.build_wr && (tbl_reg == 2'(g)))
            begin
                mem[{bi_reg, bj_reg}] <= new_val;
            end
            q[g] <= mem[raddr[g]];
        end
    end

    // cell store
    logic [CW-1:0] cell_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
        begin
            cell_mem[{lrow_reg, lcol_reg}] <= cell_value;
        end
        cell_q_reg <= cell_mem[{bi_reg, bj_reg}];
    end

    // build and evaluation pipeline registers
    always_ff @(posedge clk)
    begin
        if (cmd.build_rd)
        begin
            up_oob_reg <= (bi_reg == istart);
        end
        if (cmd.build_init)
        begin
            left_reg <= '0;
        end
        else if (cmd.build_wr)
        begin
            left_reg <= (bj_reg == jend) ? '0 : new_val;
        end
        if (cmd.eval_rd_b)
        begin
            t1_reg <= eval_sum;
        end
        if (cmd.eval_sum_b)
        begin
            t2_reg <= eval_sum;
        end
    end

    // counters, best total and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lrow_reg      <= '0;
            lcol_reg      <= '0;
            bi_reg        <= '0;
            bj_reg        <= '0;
            ei_reg        <= '0;
            ej_reg        <= '0;
            tbl_reg       <= gcpms_pkg::TBL_TL;
            best_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_total_reg <= '0;
        end
        else
        begin
            if (load_clear)
            begin
                lrow_reg <= '0;
                lcol_reg <= '0;
            end
            else if (cmd.load_wr)
            begin
                if (lcol_reg == col_last)
                begin
                    lcol_reg <= '0;
                    lrow_reg <= (lrow_reg == row_last) ? '0 : lrow_reg + DW'(1);
                end
                else
                begin
                    lcol_reg <= lcol_reg + DW'(1);
                end
                if (status.last_cell)
                begin
                    tbl_reg  <= gcpms_pkg::TBL_TL;
                    best_reg <= '0;
                end
            end

            if (cmd.build_init)
            begin
                bi_reg <= istart;
                bj_reg <= jstart;
            end
            else if (cmd.build_wr)
            begin
                if (bj_reg == jend)
                begin
                    bj_reg <= jstart;
                    bi_reg <= inext;
                    if (bi_reg == iend)
                    begin
                        tbl_reg <= tbl_reg + 2'd1;
                    end
                end
                else
                begin
                    bj_reg <= jnext;
                end
            end

            if (cmd.eval_init)
            begin
                ei_reg <= DW'(1);
                ej_reg <= DW'(1);
            end
            else if (cmd.eval_acc)
            begin
                if (ej_reg == ecol_end)
                begin
                    ej_reg <= DW'(1);
                    ei_reg <= eip;
                end
                else
                begin
                    ej_reg <= ejp;
                end
                if ((t1_reg > best_reg) || (t2_reg > best_reg))
                begin
                    best_reg <= (t1_reg > t2_reg) ? t1_reg : t2_reg;
                end
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
                out_total_reg <= best_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // status back to the controller
    always_comb
    begin
        status.last_cell     = (lrow_reg == row_last) && (lcol_reg == col_last);
        status.tbl_cell_last = (bi_reg == iend) && (bj_reg == jend);
        status.tbl_last      = (tbl_reg == gcpms_pkg::TBL_BR);
        status.small_grid    = small_grid;
        status.eval_last     = (ei_reg == erow_end) && (ej_reg == ecol_end);
        status.out_busy      = out_valid_reg;
    end

    assign out_valid  = out_valid_reg;
    assign best_total = out_total_reg;

    // checks
    a_small_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && small_grid) |=> (out_total_reg == '0))
        else $error("small grid gave a non-zero total");

    a_eval_inner: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eval_rd_a |-> (ei_reg != '0) && (ej_reg != '0)
                          && (ei_reg < row_last) && (ej_reg < col_last))
        else $error("evaluation left the inner cells");

    a_load_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_wr |-> (lrow_reg <= row_last) && (lcol_reg <= col_last))
        else $error("load position outside the grid");

endmodule

// ===== rtl/core/grid_crossing_paths_max_sum.sv =====
// top level: configuration registers, controller and datapath
`timescale 1ns / 1ps

// Loads an r-by-c grid one cell per cycle in row-major order, then computes the
// four corner path-sum tables and the best crossing total over the inner cells,
// giving one result per grid. After the last cell the block takes no cells in
// table building (four passes, each a start step and then, for every cell, a
// registered read followed by the table write), then in evaluation (a start
// step, then two reads of every table, a sum and an accumulate per inner cell;
// none when the grid has fewer than three rows or columns), nor until it loads
// the result register, which waits while an earlier result still waits there.
// A new grid can load while the previous result waits.
// Writing rows or cols restarts loading.
module grid_crossing_paths_max_sum #(
    parameter int MAX_DIM = 128
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    gcpms_in_if.sink      in,
    gcpms_out_if.source   out
);

    localparam int DW = $clog2(MAX_DIM);
    localparam int NW = $clog2(MAX_DIM + 1);
    localparam int CFW = gcpms_pkg::CFG_W;

    logic [CFW-1:0]     rows_reg, cols_reg;
    logic [NW-1:0]      r_dim, c_dim;
    logic [DW-1:0]      row_last, col_last;
    logic               small_grid;
    logic               cfg_wr;
    gcpms_pkg::cmd_t    cmd;
    gcpms_pkg::status_t status;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == gcpms_pkg::REG_COLS) ? {24'd0, cols_reg} : {24'd0, rows_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= CFW'(3);
            cols_reg <= CFW'(3);
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == gcpms_pkg::REG_COLS)
            begin
                cols_reg <= pwdata[CFW-1:0];
            end
            else
            begin
                rows_reg <= pwdata[CFW-1:0];
            end
        end
    end

    // clamp dimensions to 1..MAX_DIM
    always_comb
    begin
        if (rows_reg == '0)
        begin
            r_dim = NW'(1);
        end
        else if (32'(rows_reg) > MAX_DIM)
        begin
            r_dim = NW'(MAX_DIM);
        end
        else
        begin
            r_dim = NW'(rows_reg);
        end
        if (cols_reg == '0)
        begin
            c_dim = NW'(1);
        end
        else if (32'(cols_reg) > MAX_DIM)
        begin
            c_dim = NW'(MAX_DIM);
        end
        else
        begin
            c_dim = NW'(cols_reg);
        end
    end

    assign row_last   = DW'(r_dim - NW'(1));
    assign col_last   = DW'(c_dim - NW'(1));
    assign small_grid = (r_dim < NW'(3)) || (c_dim < NW'(3));

    gcpms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in.valid),
        .in_ready (in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    gcpms_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_clear (cfg_wr),
        .row_last   (row_last),
        .col_last   (col_last),
        .small_grid (small_grid),
        .cell_value (in.cell_value),
        .cmd        (cmd),
        .status     (status),
        .out_ready  (out.ready),
        .out_valid  (out.valid),
        .best_total (out.best_total)
    );

endmodule

// ===== bench/tb_grid_crossing_paths_max_sum.sv =====
// self-checking testbench for the grid crossing-paths maximum-sum block
`timescale 1ns / 1ps

module tb_grid_crossing_paths_max_sum;

    localparam int DIM_LIMIT = 128;
    localparam int CELL_GOAL = 2000;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int CW = gcpms_pkg::CELL_W;
    localparam int TW = gcpms_pkg::TOTAL_W;
    localparam logic [2:0] ROWS_ADDR = {gcpms_pkg::REG_ROWS, 2'b00};
    localparam logic [2:0] COLS_ADDR = {gcpms_pkg::REG_COLS, 2'b00};

    typedef enum int {FILL_ZERO, FILL_MAX, FILL_RAND, FILL_RAMP} fill_t;

    typedef struct {
        int    rows_val;
        int    cols_val;
        fill_t fill;
        bit    has_total;
        int    total;
    } grid_case_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    gcpms_in_if  cell_ch ();
    gcpms_out_if total_ch ();

    grid_crossing_paths_max_sum dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in      (cell_ch.source),
        .out     (total_ch.sink)
    );

    // predictor state
    logic [CW-1:0]  grid_mem [DIM_LIMIT][DIM_LIMIT];
    logic [TW-1:0]  path_tbl [4][DIM_LIMIT][DIM_LIMIT];
    int unsigned    rows_reg;
    int unsigned    cols_reg;
    int unsigned    fill_cnt;
    logic [TW-1:0]  totals_q [$];

    int  fail_cnt;
    int  cycle_cnt;
    int  cells_sent;
    bit  calm_out;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("grid_crossing_paths_max_sum regression: fail");
            $finish;
        end
    end

    function automatic int unsigned dim_used(int unsigned d);
        if (d < 1) return 1;
        if (d > DIM_LIMIT) return DIM_LIMIT;
        return d;
    endfunction

    function automatic logic [TW-1:0] add_sat(logic [TW-1:0] a,
                                              logic [TW-1:0] b);
        logic [TW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TW] ? {TW{1'b1}} : s[TW-1:0];
    endfunction

    function automatic logic [TW-1:0] path_at(int t, int i, int j, int r, int c);
        if (i < 0 || j < 0 || i >= r || j >= c) return '0;
        return path_tbl[t][i][j];
    endfunction

    function automatic logic [TW-1:0] quad_sum(logic [TW-1:0] p,
                                               logic [TW-1:0] q,
                                               logic [TW-1:0] s,
                                               logic [TW-1:0] u);
        return add_sat(add_sat(p, q), add_sat(s, u));
    endfunction

    // four corner tables, then the best crossing over inner cells
    function automatic logic [TW-1:0] best_crossing(int r, int c);
        int di;
        int dj;
        int i;
        int j;
        logic [TW-1:0] prev;
        logic [TW-1:0] t1;
        logic [TW-1:0] t2;
        logic [TW-1:0] best;
        for (int t = 0; t < 4; t++)
        begin
            di = t[0] ? -1 : 1;
            dj = t[1] ? -1 : 1;
            for (int a = 0; a < r; a++)
            begin
                i = (di > 0) ? a : r - 1 - a;
                for (int b = 0; b < c; b++)
                begin
                    j = (dj > 0) ? b : c - 1 - b;
                    prev = path_at(t, i - di, j, r, c);
                    if (path_at(t, i, j - dj, r, c) > prev)
                        prev = path_at(t, i, j - dj, r, c);
                    path_tbl[t][i][j] = add_sat(TW'(grid_mem[i][j]), prev);
                end
            end
        end
        best = '0;
        for (i = 1; i + 1 < r; i++)
        begin
            for (j = 1; j + 1 < c; j++)
            begin
                t1 = quad_sum(path_at(gcpms_pkg::TBL_TL, i - 1, j, r, c),
                              path_at(gcpms_pkg::TBL_BL, i, j - 1, r, c),
                              path_at(gcpms_pkg::TBL_BR, i + 1, j, r, c),
                              path_at(gcpms_pkg::TBL_TR, i, j + 1, r, c));
                t2 = quad_sum(path_at(gcpms_pkg::TBL_TL, i, j - 1, r, c),
                              path_at(gcpms_pkg::TBL_BL, i + 1, j, r, c),
                              path_at(gcpms_pkg::TBL_TR, i - 1, j, r, c),
                              path_at(gcpms_pkg::TBL_BR, i, j + 1, r, c));
                if (t1 > best) best = t1;
                if (t2 > best) best = t2;
            end
        end
        return best;
    endfunction

    // update the predictor with one accepted cell
    task automatic absorb_cell(logic [CW-1:0] v);
        int unsigned r;
        int unsigned c;
        int unsigned k;
        r = dim_used(rows_reg);
        c = dim_used(cols_reg);
        k = fill_cnt;
        if (k >= r * c) k = 0;
        grid_mem[k / c][k % c] = v;
        k++;
        if (k < r * c)
            fill_cnt = k;
        else
        begin
            fill_cnt = 0;
            totals_q.push_back(best_crossing(r, c));
        end
    endtask

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // one cell transfer, valid held high across back-to-back cells
    task automatic send_cell(logic [CW-1:0] v, bit calm);
        int gap;
        gap = calm ? 0 : gap_len();
        if (gap > 0)
        begin
            cell_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cell_ch.valid      <= 1'b1;
        cell_ch.cell_value <= v;
        do
            @(posedge clk);
        while (!cell_ch.ready);
        absorb_cell(v);
        cells_sent++;
    endtask

    task automatic drain();
        cell_ch.valid <= 1'b0;
        @(posedge clk);
        while (totals_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // register write after draining pending results: setup then access
    task automatic reg_write(logic [2:0] addr, int unsigned value);
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ROWS_ADDR)
            rows_reg = value & 8'hff;
        else
            cols_reg = value & 8'hff;
        fill_cnt = 0;
    endtask

    function automatic logic [CW-1:0] cell_for(fill_t f, int idx);
        int p;
        case (f)
            FILL_ZERO: return '0;
            FILL_MAX:  return {CW{1'b1}};
            FILL_RAMP: return CW'(idx * 977);
            default:
            begin
                p = $urandom_range(0, 9);
                if (p == 0) return '0;
                if (p == 1) return {CW{1'b1}};
                if (p < 4) return CW'($urandom_range(0, 15));
                return CW'($urandom);
            end
        endcase
    endfunction

    task automatic send_grid(fill_t f, bit calm);
        int n;
        n = dim_used(rows_reg) * dim_used(cols_reg);
        for (int k = 0; k < n; k++)
            send_cell(cell_for(f, k), calm);
    endtask

    // result side: random stalls, with calm stretches
    initial
    begin
        int stall;
        stall = 0;
        total_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (total_ch.valid && total_ch.ready)
            begin
                if (totals_q.size() == 0)
                begin
                    $error("best_total: no result expected, actual %0d", total_ch.best_total);
                    fail_cnt++;
                end
                else if (total_ch.best_total !== totals_q[0])
                begin
                    $error("best_total: expected %0d, actual %0d",
                           totals_q[0], total_ch.best_total);
                    fail_cnt++;
                    void'(totals_q.pop_front());
                end
                else
                    void'(totals_q.pop_front());
            end
            if (cycle_cnt % 3000 == 0) calm_out = $urandom_range(0, 3) == 0;
            if (stall > 0)
            begin
                total_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                total_ch.ready <= 1'b1;
                if (!calm_out) stall = gap_len();
            end
        end
    end

    grid_case_t grid_cases [] = '{
        '{3, 3, FILL_ZERO, 1'b1, 0},
        '{3, 3, FILL_MAX, 1'b1, 1048568},
        '{0, 0, FILL_MAX, 1'b1, 0},
        '{2, 5, FILL_RAND, 1'b1, 0},
        '{3, 4, FILL_RAMP, 1'b0, 0}
    };

    // stimulus
    initial
    begin
        int r;
        int c;
        int n;
        int p;
        bit calm;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cell_ch.valid = 1'b0;
        cell_ch.cell_value = '0;
        rows_reg = 3;
        cols_reg = 3;
        fill_cnt = 0;
        fail_cnt = 0;
        cycle_cnt = 0;
        cells_sent = 0;
        calm_out = 1'b0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset dimensions first, then the directed grids
        send_grid(FILL_RAND, 1'b0);
        foreach (grid_cases[g])
        begin
            if (g > 0)
            begin
                reg_write(ROWS_ADDR, grid_cases[g].rows_val);
                reg_write(COLS_ADDR, grid_cases[g].cols_val);
            end
            send_grid(grid_cases[g].fill, 1'b0);
            if (grid_cases[g].has_total)
                totals_q[totals_q.size() - 1] = grid_cases[g].total;
        end

        // partial grid abandoned by a register write
        for (int k = 0; k < 5; k++)
            send_cell(cell_for(FILL_MAX, k), 1'b0);
        reg_write(COLS_ADDR, 3);
        send_grid(FILL_RAND, 1'b0);

        // random phases
        while (cells_sent < CELL_GOAL)
        begin
            p = $urandom_range(0, 99);
            if (p < 3)
            begin
                r = 255;
                c = $urandom_range(1, 3);
            end
            else if (p < 6)
            begin
                r = $urandom_range(3, 4);
                c = $urandom_range(0, 1) ? 128 : 255;
            end
            else if (p < 8)
            begin
                r = 0;
                c = $urandom_range(0, 4);
            end
            else
            begin
                r = $urandom_range(1, 9);
                c = $urandom_range(1, 9);
            end
            reg_write(ROWS_ADDR, r);
            reg_write(COLS_ADDR, c);
            calm = $urandom_range(0, 4) == 0;
            n = (dim_used(r) * dim_used(c) > 100) ? 1 : $urandom_range(1, 4);
            for (int g = 0; g < n; g++)
            begin
                send_grid(FILL_RAND, calm);
                if ($urandom_range(0, 9) == 0)
                    drain();
            end
            // now and then a broken grid cut short by the next write
            if ($urandom_range(0, 7) == 0)
            begin
                n = $urandom_range(1, dim_used(r) * dim_used(c));
                for (int k = 0; k < n - 1; k++)
                    send_cell(cell_for(FILL_RAND, k), calm);
            end
        end

        drain();
        repeat (50) @(posedge clk);
        if (fail_cnt == 0)
            $display("grid_crossing_paths_max_sum regression: pass");
        else
            $display("grid_crossing_paths_max_sum regression: fail");
        $finish;
    end

endmodule
